// File: sv/box_mean_filter_core_defines.svh
// Assertion macros shared by the box mean filter RTL.
// Depends on nothing; included by the files that assert.
`ifndef BOX_MEAN_FILTER_CORE_DEFINES_SVH
`define BOX_MEAN_FILTER_CORE_DEFINES_SVH
// Check that an antecedent implies a consequent in the next cycle.
`define BMF_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define BMF_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`endif

// File: sv/bmf_pkg.sv
// Package of the box mean filter: job record passed front to back, constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bmf_pkg;
  localparam int unsigned SLOTS = 5;
  localparam int unsigned CW = 13;    // coordinate width, covers up to 4096
  localparam int unsigned SW = 13;    // window sum, 25 * 255 fits

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIVE   = 2'd2;

  // Line store row slot, row number modulo SLOTS.
  typedef logic [2:0] slot_t;

  // One output pixel to be computed: its window bounds and position.
  typedef struct packed {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic [CW-1:0] top;
    logic [CW-1:0] bot;
    logic [CW-1:0] lef;
    logic [CW-1:0] rig;
    slot_t         top_slot;
    logic          last;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_OUT
  } back_state_t;

  // Advance a row slot, wrapping after the last one.
  function automatic slot_t slot_inc(input slot_t s);
    return (s == slot_t'(SLOTS - 1)) ? slot_t'(0) : s + slot_t'(1);
  endfunction

  // Reciprocal-free division: count is at most 25, iterate restoring steps.
endpackage
`default_nettype wire

// File: sv/bmf_front.sv
// Front part: tracks raster position, writes line store, emits job records.
// Depends on bmf_pkg. Writes the store through ports to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bmf_front #(
  parameter int unsigned MAXW = 1024,
  parameter int unsigned MAXH = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    restart,
  input  wire logic [10:0]             cfg_w,
  input  wire logic [10:0]             cfg_h,
  input  wire logic                    cfg_five,
  input  wire logic                    hold_in,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  output logic                         job_valid,
  input  wire logic                    job_ready,
  output bmf_pkg::job_t                job,
  output logic                         wr_en,
  output bmf_pkg::slot_t               wr_slot,
  output logic [bmf_pkg::CW-1:0]       wr_col
);
  localparam int unsigned CW = bmf_pkg::CW;
  logic [CW-1:0] w, h, half;
  logic [CW-1:0] row_count, col_count;
  logic          busy;
  logic [CW-1:0] rlo, rhi, clo, chi, r, c;
  logic          rok, cok;
  logic [CW-1:0] cur_r, cur_c;
  bmf_pkg::slot_t row_slot, cur_slot;
  logic [2:0]    top_diff;

  always_comb begin
    w = (cfg_w == 11'd0) ? CW'(1) : (CW'(cfg_w) > CW'(MAXW) ? CW'(MAXW) : CW'(cfg_w));
    h = (cfg_h == 11'd0) ? CW'(1) : (CW'(cfg_h) > CW'(MAXH) ? CW'(MAXH) : CW'(cfg_h));
    half = cfg_five ? CW'(2) : CW'(1);
  end

  always_comb begin
    rok = 1'b0; rlo = '0; rhi = '0;
    if (row_count + CW'(1) == h) begin
      rok = 1'b1; rhi = h - CW'(1);
      rlo = (h - CW'(1) >= half) ? h - CW'(1) - half : '0;
    end else if (row_count >= half) begin
      rok = 1'b1; rlo = row_count - half; rhi = rlo;
    end
    cok = 1'b0; clo = '0; chi = '0;
    if (col_count + CW'(1) == w) begin
      cok = 1'b1; chi = w - CW'(1);
      clo = (w - CW'(1) >= half) ? w - CW'(1) - half : '0;
    end else if (col_count >= half) begin
      cok = 1'b1; clo = col_count - half; chi = clo;
    end
  end

  assign in_ready = !busy && !restart && !hold_in;
  assign wr_en    = in_valid && in_ready;
  assign wr_slot  = row_slot;
  assign wr_col   = col_count;

  // Iterate over the ready rectangle, one job per cycle while job_ready is high.
  assign job_valid = busy;
  always_comb begin
    job.row  = r;
    job.col  = c;
    job.top  = (r >= half) ? r - half : '0;
    job.bot  = (r + half < h) ? r + half : h - CW'(1);
    job.lef  = (c >= half) ? c - half : '0;
    job.rig  = (c + half < w) ? c + half : w - CW'(1);
    job.last = (r == rhi) && (c == chi);
    // top row lies at most four rows above the current one
    top_diff = 3'(cur_r - job.top);
    job.top_slot = (cur_slot >= top_diff) ? cur_slot - top_diff
                                          : cur_slot + 3'(bmf_pkg::SLOTS) - top_diff;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b0;
      row_count <= '0;
      col_count <= '0;
      row_slot <= '0;
    end else if (busy) begin
      if (job_ready) begin
        if (job.last) begin
          busy <= 1'b0;
          if (cur_c + CW'(1) >= w) begin
            col_count <= '0;
            if (cur_r + CW'(1) >= h) begin
              row_count <= '0;
              row_slot <= '0;
            end else begin
              row_count <= cur_r + CW'(1);
              row_slot <= bmf_pkg::slot_inc(cur_slot);
            end
          end else begin
            col_count <= cur_c + CW'(1);
          end
        end else if (c == chi) begin
          c <= clo;
          r <= r + CW'(1);
        end else begin
          c <= c + CW'(1);
        end
      end
    end else if (wr_en) begin
      cur_r <= row_count;
      cur_c <= col_count;
      cur_slot <= row_slot;
      if (rok && cok) begin
        busy <= 1'b1;
        r <= rlo;
        c <= clo;
      end else if (col_count + CW'(1) >= w) begin
        col_count <= '0;
        if (row_count + CW'(1) >= h) begin
          row_count <= '0;
          row_slot <= '0;
        end else begin
          row_count <= row_count + CW'(1);
          row_slot <= bmf_pkg::slot_inc(row_slot);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/bmf_back.sv
// Back part: sums the window from the line store and divides by the count.
// Depends on bmf_pkg and the defines header; reads the store held here.
`timescale 1ns / 1ps
`default_nettype none
`include "box_mean_filter_core_defines.svh"
module bmf_back #(
  parameter int unsigned MAXW = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  bmf_pkg::slot_t             wr_slot,
  input  wire logic [bmf_pkg::CW-1:0] wr_col,
  input  wire logic [7:0]            wr_data,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  input  bmf_pkg::job_t              job,
  output logic                       rd_busy,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic [7:0]                 res_pixel,
  output logic [9:0]                 res_row,
  output logic [9:0]                 res_col,
  output logic                       res_last
);
  localparam int unsigned CW = bmf_pkg::CW;
  localparam int unsigned SW = bmf_pkg::SW;
  localparam int unsigned AW = $clog2(bmf_pkg::SLOTS * MAXW);
  localparam int unsigned XW = $clog2(MAXW);

  logic [7:0] mem [bmf_pkg::SLOTS * MAXW];
  logic [7:0] rd_data;
  logic [AW-1:0] wa, ra;

  bmf_pkg::back_state_t state, state_next;
  bmf_pkg::job_t j;
  logic [CW-1:0] i, k;
  bmf_pkg::slot_t islot;
  logic          rd_pend;
  logic          tail;
  logic [SW-1:0] sum, rem;
  logic [4:0]    cnt;
  logic [7:0]    quo;
  logic [3:0]    step;
  logic          sweep_done;
  logic [SW:0]   trial;

  function automatic logic [AW-1:0] addr(input bmf_pkg::slot_t slot,
                                         input logic [CW-1:0] col);
    return AW'(slot) * AW'(MAXW) + AW'(col[XW-1:0]);
  endfunction

  assign wa = addr(wr_slot, wr_col);
  assign ra = addr(islot, k);
  always_ff @(posedge clk) begin
    if (wr_en) mem[wa] <= wr_data;
    rd_data <= mem[ra];
  end

  assign sweep_done = (i == j.bot) && (k == j.rig);
  assign trial = {rem, quo[7]} - {1'b0, 8'd0, cnt};

  always_comb begin
    state_next = state;
    unique case (state)
      bmf_pkg::B_IDLE: if (job_valid) state_next = bmf_pkg::B_SUM;
      bmf_pkg::B_SUM:  if (tail) state_next = bmf_pkg::B_DIV;
      bmf_pkg::B_DIV:  if (step == 4'd8) state_next = bmf_pkg::B_OUT;
      bmf_pkg::B_OUT:  if (res_ready) state_next = bmf_pkg::B_IDLE;
      default:         state_next = bmf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == bmf_pkg::B_IDLE);
    rd_busy   = (state == bmf_pkg::B_SUM);
    res_valid = (state == bmf_pkg::B_OUT);
    res_pixel = quo;
    res_row   = j.row[9:0];
    res_col   = j.col[9:0];
    res_last  = j.last;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bmf_pkg::B_IDLE;
    else state <= state_next;
    unique case (state)
      bmf_pkg::B_IDLE: begin
        j <= job; i <= job.top; k <= job.lef; islot <= job.top_slot;
        sum <= '0; cnt <= '0; rd_pend <= 1'b0; tail <= 1'b0;
      end
      bmf_pkg::B_SUM: begin
        // read issued at (i,k) this cycle; accumulate previous read
        if (rd_pend) begin
          sum <= sum + SW'(rd_data);
          cnt <= cnt + 5'd1;
        end
        if (tail) begin
          // place dividend for shift-subtract loop
          step <= '0;
          rem  <= (sum + SW'(rd_data)) >> 8;
          quo  <= 8'((sum + SW'(rd_data)));
        end else begin
          rd_pend <= 1'b1;
          if (sweep_done) tail <= 1'b1;
          else if (k == j.rig) begin
            i <= i + CW'(1); k <= j.lef; islot <= bmf_pkg::slot_inc(islot);
          end else k <= k + CW'(1);
        end
      end
      bmf_pkg::B_DIV: begin
        if (step != 4'd8) begin
          step <= step + 4'd1;
          if (!trial[SW]) begin
            rem <= trial[SW-1:0];
            quo <= {quo[6:0], 1'b1};
          end else begin
            rem <= {rem[SW-2:0], quo[7]};
            quo <= {quo[6:0], 1'b0};
          end
        end
      end
      bmf_pkg::B_OUT: ;
      default: ;
    endcase
  end

  `BMF_ASSERT_NOW(a_out_hold, clk, rst, res_valid && !res_ready, !job_ready)
  `BMF_ASSERT_NEXT(a_div_len, clk, rst, state == bmf_pkg::B_DIV && step == 4'd8, res_valid)
  `BMF_ASSERT_NOW(a_cnt_max, clk, rst, state == bmf_pkg::B_DIV, cnt != 5'd0 && cnt <= 5'd25)
endmodule
`default_nettype wire

// File: sv/box_mean_filter_core.sv
// Top level of the box mean filter: APB registers, front and back parts.
// Depends on bmf_pkg, bmf_front and bmf_back.
// Usage:
//   Input queue: drive in_pixel and push; a transaction completes when push
//   is high and full is low. Pixels come in raster order of one frame.
//   Result queue: out_pixel, out_row, out_col and last_in_run are valid
//   while empty is low; pop takes the transaction.
//   Each input yields zero to nine results; the front part walks the
//   rectangle of ready windows, one job per cycle while the back is idle,
//   and holds the input (full high) until every job of that pixel has been
//   handed over. The back part reads the window from the line store one
//   pixel a cycle, then runs an 8-step shift-subtract divide and holds the
//   result until it is popped; the single back unit sets the rate.
//   The back part latches each job into its own register while idle.
//   Reset clears position counters and control state; the store is not
//   cleared. Writing any register restarts the frame.
//   When the receiver stalls, the result stays on the ports and the back
//   part holds; input stalls once the front has a pending job or while
//   the back part reads the store.
`timescale 1ns / 1ps
`default_nettype none
module box_mean_filter_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_pixel,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_pixel,
  output logic [9:0]       out_row,
  output logic [9:0]       out_col,
  output logic             last_in_run
);
  logic [10:0] image_width, image_height;
  logic        window_five, wr, in_ready, jv, jr, rv, rd_busy;
  bmf_pkg::job_t job;
  logic        wen;
  bmf_pkg::slot_t wslot;
  logic [bmf_pkg::CW-1:0] wcol;

  assign pready = 1'b1;
  // Decode an APB write, which updates the register and restarts the frame.
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd512; image_height <= 11'd512; window_five <= 1'b0;
    end else if (wr) begin
      unique case (paddr[3:2])
        bmf_pkg::REG_WIDTH:  image_width  <= pwdata[10:0];
        bmf_pkg::REG_HEIGHT: image_height <= pwdata[10:0];
        bmf_pkg::REG_FIVE:   window_five  <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      bmf_pkg::REG_WIDTH:  prdata = {21'd0, image_width};
      bmf_pkg::REG_HEIGHT: prdata = {21'd0, image_height};
      bmf_pkg::REG_FIVE:   prdata = {31'd0, window_five};
      default:             prdata = 32'd0;
    endcase
  end

  assign full  = !in_ready;
  assign empty = !rv;

  bmf_front #(.MAXW(MAX_WIDTH), .MAXH(MAX_HEIGHT)) u_front (
    .clk, .rst, .restart(wr && paddr[3:2] != 2'd3),
    .cfg_w(image_width), .cfg_h(image_height), .cfg_five(window_five),
    .hold_in(rd_busy),
    .in_valid(push), .in_ready, .job_valid(jv), .job_ready(jr), .job,
    .wr_en(wen), .wr_slot(wslot), .wr_col(wcol)
  );

  bmf_back #(.MAXW(MAX_WIDTH)) u_back (
    .clk, .rst, .wr_en(wen), .wr_slot(wslot), .wr_col(wcol), .wr_data(in_pixel),
    .job_valid(jv), .job_ready(jr), .job, .rd_busy,
    .res_valid(rv), .res_ready(pop), .res_pixel(out_pixel),
    .res_row(out_row), .res_col(out_col), .res_last(last_in_run)
  );
endmodule
`default_nettype wire
